[rtl/shared_buffer_multi_queue_core_defines.svh]
// Assertion macros shared by the shared-buffer multi-queue RTL.
`ifndef SHARED_BUFFER_MULTI_QUEUE_CORE_DEFINES_SVH
`define SHARED_BUFFER_MULTI_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SBMQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SBMQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sbmq_pkg.sv]
// Types and constants of the shared-buffer multi-queue.
package sbmq_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int QUEUES_DEF = 4;
  localparam int QID_W      = 2;
  localparam int DATA_W     = 32;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } sbmq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_QRD,
    S_SRD
  } sbmq_state_e;

  typedef struct packed {
    logic                     command;
    logic [QID_W-1:0]         queue_id;
    logic signed [DATA_W-1:0] write_data;
  } sbmq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    sbmq_status_e             status;
  } sbmq_out_t;

  // Queue table access controls.
  typedef struct packed {
    logic rd;
    logic wr;
    logic set_ne;
    logic clr_ne;
  } sbmq_qtab_ctl_t;

  // Slot store access controls; every data write allocates its slot.
  typedef struct packed {
    logic rd;
    logic link_wr;
    logic data_wr;
  } sbmq_slot_ctl_t;

endpackage

[rtl/shared_buffer_multi_queue_core.sv]
// Enqueue or refused command: queue table read (S_QRD); dequeue: queue table read, then slot read (S_SRD).
// Each result passes the staging register, then the result register. A new command is taken only in S_IDLE,
// after the queue table read and, for a dequeue, the dependent slot link/data read.
// One result register plus one staging register let a command be accepted while a result waits.
// Reset clears control, the free-list head and all non-empty flags; the free list of the
// slot store comes from a fill count, so no clearing pass runs and commands are taken at once.
`include "shared_buffer_multi_queue_core_defines.svh"
module shared_buffer_multi_queue_core
  import sbmq_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEF,
  parameter int QUEUES = QUEUES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sbmq_in_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sbmq_out_t out_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  sbmq_state_e state_q, state_d;

  logic                     cmd_q;
  logic [QW-1:0]            qidx_q;
  logic                     qok_q;
  logic signed [DATA_W-1:0] wdata_q;
  logic [PW-1:0]            free_head_q, free_head_d;

  sbmq_out_t stg_q, stg_d, out_q;
  logic      stg_vld_q, stg_vld_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;
  logic      in_hs;
  logic      done;
  logic      free_ok;

  sbmq_qtab_ctl_t qt_ctl;
  logic [QW-1:0]  qt_addr;
  logic [IW-1:0]  qt_head_wr, qt_tail_wr, qt_head_rd, qt_tail_rd;
  logic           q_ne;

  sbmq_slot_ctl_t           sl_ctl;
  logic [IW-1:0]            sl_rd_addr, sl_link_wr_addr, sl_data_wr_addr;
  logic [PW-1:0]            sl_link_wr_data, sl_link_rd;
  logic signed [DATA_W-1:0] sl_data_rd;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && (!stg_vld_q || out_free);
  assign in_hs      = in_valid_i && in_ready_o;
  assign free_ok    = free_head_q < NIL;

  sbmq_qtab #(
    .QUEUES (QUEUES),
    .IW     (IW),
    .QW     (QW)
  ) u_qtab (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (qt_ctl),
    .addr_i (qt_addr),
    .head_i (qt_head_wr),
    .tail_i (qt_tail_wr),
    .head_o (qt_head_rd),
    .tail_o (qt_tail_rd),
    .ne_o   (q_ne)
  );

  sbmq_slots #(
    .SLOTS (SLOTS),
    .IW    (IW),
    .PW    (PW)
  ) u_slots (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (sl_ctl),
    .rd_addr_i      (sl_rd_addr),
    .link_wr_addr_i (sl_link_wr_addr),
    .link_wr_data_i (sl_link_wr_data),
    .data_wr_addr_i (sl_data_wr_addr),
    .data_wr_data_i (wdata_q),
    .link_rd_o      (sl_link_rd),
    .data_rd_o      (sl_data_rd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_hs) state_d = S_QRD;
      end
      S_QRD: begin
        if ((cmd_q == CMD_DEQ) && qok_q && q_ne) begin
          state_d = S_SRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SRD: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Memory controls, free-list update and result.
  always_comb begin
    qt_ctl          = '0;
    qt_addr         = qidx_q;
    qt_head_wr      = qt_head_rd;
    qt_tail_wr      = qt_tail_rd;
    sl_ctl          = '0;
    sl_rd_addr      = free_head_q[IW-1:0];
    sl_link_wr_addr = qt_tail_rd;
    sl_link_wr_data = free_head_q;
    sl_data_wr_addr = free_head_q[IW-1:0];
    free_head_d     = free_head_q;
    done            = 1'b0;
    stg_d.read_data = '0;
    stg_d.status    = ST_DONE;
    case (state_q)
      S_IDLE: begin
        qt_addr   = QW'(in_i.queue_id);
        qt_ctl.rd = in_hs;
        // Prefetch the link of the free head for a possible enqueue.
        sl_ctl.rd = in_hs && free_ok;
      end
      S_QRD: begin
        if (cmd_q == CMD_ENQ) begin
          done = 1'b1;
          if (!qok_q || !free_ok) begin
            stg_d.status = ST_FULL;
          end else begin
            sl_ctl.data_wr  = 1'b1;
            sl_ctl.link_wr  = q_ne;
            sl_link_wr_addr = qt_tail_rd;
            sl_link_wr_data = free_head_q;
            qt_ctl.wr       = 1'b1;
            qt_ctl.set_ne   = 1'b1;
            qt_head_wr      = q_ne ? qt_head_rd : free_head_q[IW-1:0];
            qt_tail_wr      = free_head_q[IW-1:0];
            free_head_d     = (sl_link_rd < NIL) ? sl_link_rd : NIL;
          end
        end else if (!qok_q || !q_ne) begin
          done         = 1'b1;
          stg_d.status = ST_EMPTY;
        end else begin
          sl_ctl.rd  = 1'b1;
          sl_rd_addr = qt_head_rd;
        end
      end
      S_SRD: begin
        // Unlink the head; drop the queue to empty when head and tail meet.
        done            = 1'b1;
        qt_ctl.wr       = 1'b1;
        qt_ctl.clr_ne   = (qt_head_rd == qt_tail_rd);
        qt_head_wr      = sl_link_rd[IW-1:0];
        qt_tail_wr      = qt_tail_rd;
        sl_ctl.link_wr  = 1'b1;
        sl_link_wr_addr = qt_head_rd;
        sl_link_wr_data = free_head_q;
        free_head_d     = PW'(qt_head_rd);
        stg_d.read_data = sl_data_rd;
        stg_d.status    = ST_DONE;
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_comb begin
    stg_vld_d = stg_vld_q;
    if (done) begin
      stg_vld_d = 1'b1;
    end else if (out_free) begin
      stg_vld_d = 1'b0;
    end
    out_valid_d = out_free ? stg_vld_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      stg_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      stg_vld_q   <= stg_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      cmd_q   <= in_i.command;
      qidx_q  <= QW'(in_i.queue_id);
      qok_q   <= (int'(in_i.queue_id) < QUEUES);
      wdata_q <= in_i.write_data;
    end
    if (done) begin
      stg_q <= stg_d;
    end
    if (out_free && stg_vld_q) begin
      out_q <= stg_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `SBMQ_ASSERT_IMP(a_stage_free_at_done, done, !stg_vld_q, "result staged while stage is full")
  `SBMQ_ASSERT_NXT(a_done_fills_stage, done, stg_vld_q, "finished transaction not staged")
  `SBMQ_ASSERT_IMP(a_srd_after_qrd, state_q == S_SRD, $past(state_q) == S_QRD, "slot read without queue read")
  `SBMQ_ASSERT_IMP(a_free_head_range, 1'b1, free_head_q <= NIL, "free head out of range")

endmodule

[rtl/sbmq_qtab.sv]
// Queue table: head/tail memory per queue plus non-empty flags.
module sbmq_qtab
  import sbmq_pkg::*;
#(
  parameter int QUEUES = QUEUES_DEF,
  parameter int IW     = 4,
  parameter int QW     = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sbmq_qtab_ctl_t ctl_i,
  input  logic [QW-1:0]  addr_i,
  input  logic [IW-1:0]  head_i,
  input  logic [IW-1:0]  tail_i,
  output logic [IW-1:0]  head_o,
  output logic [IW-1:0]  tail_o,
  output logic           ne_o
);

  logic [2*IW-1:0] mem_q [QUEUES];
  logic [2*IW-1:0] rdata_q;
  logic [QUEUES-1:0] ne_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[addr_i] <= {head_i, tail_i};
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q <= '0;
    end else if (ctl_i.set_ne) begin
      ne_q[addr_i] <= 1'b1;
    end else if (ctl_i.clr_ne) begin
      ne_q[addr_i] <= 1'b0;
    end
  end

  assign head_o = rdata_q[2*IW-1:IW];
  assign tail_o = rdata_q[IW-1:0];
  assign ne_o   = ne_q[addr_i];

endmodule

[rtl/sbmq_slots.sv]
// Slot store: link and data memories with a fill count for the initial free list.
`include "shared_buffer_multi_queue_core_defines.svh"
module sbmq_slots
  import sbmq_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int IW    = 4,
  parameter int PW    = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sbmq_slot_ctl_t           ctl_i,
  input  logic [IW-1:0]            rd_addr_i,
  input  logic [IW-1:0]            link_wr_addr_i,
  input  logic [PW-1:0]            link_wr_data_i,
  input  logic [IW-1:0]            data_wr_addr_i,
  input  logic signed [DATA_W-1:0] data_wr_data_i,
  output logic [PW-1:0]            link_rd_o,
  output logic signed [DATA_W-1:0] data_rd_o
);

  logic [PW-1:0]            link_mem_q [SLOTS];
  logic signed [DATA_W-1:0] data_mem_q [SLOTS];
  logic [PW-1:0]            link_rd_q;
  logic signed [DATA_W-1:0] data_rd_q;
  logic [IW-1:0]            rd_addr_q;
  logic                     rd_fresh_q;
  logic [PW-1:0]            fill_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.link_wr) begin
      link_mem_q[link_wr_addr_i] <= link_wr_data_i;
    end
    if (ctl_i.data_wr) begin
      data_mem_q[data_wr_addr_i] <= data_wr_data_i;
    end
    if (ctl_i.rd) begin
      link_rd_q  <= link_mem_q[rd_addr_i];
      data_rd_q  <= data_mem_q[rd_addr_i];
      rd_addr_q  <= rd_addr_i;
      rd_fresh_q <= (PW'(rd_addr_i) >= fill_q);
    end
  end

  // Slots at or above the fill count were never allocated: each links to its successor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (ctl_i.data_wr && (PW'(data_wr_addr_i) == fill_q)) begin
      fill_q <= fill_q + PW'(1);
    end
  end

  assign link_rd_o = rd_fresh_q ? (PW'(rd_addr_q) + PW'(1)) : link_rd_q;
  assign data_rd_o = data_rd_q;

  `SBMQ_ASSERT_IMP(a_alloc_in_order, ctl_i.data_wr, PW'(data_wr_addr_i) <= fill_q, "slot allocated past fill count")
  `SBMQ_ASSERT_IMP(a_fill_range, 1'b1, fill_q <= PW'(SLOTS), "fill count beyond slot count")

endmodule

[sim/testbench.sv]
// Self-checking testbench for the shared-buffer multi-queue core.
`timescale 1ns / 1ps

module testbench;
  import sbmq_pkg::*;

  localparam int NSLOTS    = SLOTS_DEF;
  localparam int NQUEUES   = QUEUES_DEF;
  localparam int PTR_W     = $clog2(NSLOTS + 1);
  localparam int SIDX_W    = $clog2(NSLOTS);
  localparam int QIDX_W    = (NQUEUES > 1) ? $clog2(NQUEUES) : 1;
  localparam int RAND_CMDS = 1200;
  localparam int MAX_GAP   = 16;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(NSLOTS);

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  sbmq_in_t  in_i;
  logic      out_valid_o;
  logic      out_ready_i;
  sbmq_out_t out_o;

  shared_buffer_multi_queue_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // Shadow copy of the slot store and the queue pointers.
  logic signed [DATA_W-1:0] shadow_data [NSLOTS];
  logic [PTR_W-1:0]         shadow_link [NSLOTS];
  logic [PTR_W-1:0]         shadow_free;
  logic [PTR_W-1:0]         shadow_head [NQUEUES];
  logic [PTR_W-1:0]         shadow_tail [NQUEUES];

  sbmq_in_t  pending_cmds[$];
  sbmq_out_t expected_results[$];

  int total_cmds;
  int accepted_cmds;
  int error_count;
  int enq_done;
  int enq_full;
  int deq_done;
  int deq_empty;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void reset_shadow();
    for (int i = 0; i < NSLOTS; i++) begin
      shadow_data[SIDX_W'(i)] = '0;
      shadow_link[SIDX_W'(i)] = (i + 1 < NSLOTS) ? PTR_W'(i + 1) : NIL;
    end
    shadow_free = '0;
    for (int i = 0; i < NQUEUES; i++) begin
      shadow_head[QIDX_W'(i)] = NIL;
      shadow_tail[QIDX_W'(i)] = '0;
    end
  endfunction

  // Apply one command to the shadow state and return the result it produces.
  function automatic sbmq_out_t apply_command(sbmq_in_t c);
    sbmq_out_t         r;
    logic [PTR_W-1:0]  s;
    logic [SIDX_W-1:0] si;
    logic [SIDX_W-1:0] ti;
    logic [QIDX_W-1:0] qi;
    int                q;
    r.read_data = '0;
    r.status    = ST_DONE;
    q  = int'(c.queue_id);
    qi = QIDX_W'(c.queue_id);
    if (c.command == CMD_ENQ) begin
      s  = shadow_free;
      si = s[SIDX_W-1:0];
      if (q >= NQUEUES || s >= NSLOTS) begin
        r.status = ST_FULL;
      end else begin
        shadow_free = (shadow_link[si] < NSLOTS) ? shadow_link[si] : NIL;
        if (shadow_head[qi] >= NSLOTS) begin
          shadow_head[qi] = s;
        end else if (shadow_tail[qi] < NSLOTS) begin
          ti = shadow_tail[qi][SIDX_W-1:0];
          shadow_link[ti] = s;
        end
        shadow_link[si] = NIL;
        shadow_tail[qi] = s;
        shadow_data[si] = c.write_data;
      end
    end else begin
      if (q >= NQUEUES || shadow_head[qi] >= NSLOTS) begin
        r.status = ST_EMPTY;
      end else begin
        s  = shadow_head[qi];
        si = s[SIDX_W-1:0];
        shadow_head[qi] = (shadow_link[si] < NSLOTS) ? shadow_link[si] : NIL;
        shadow_link[si] = shadow_free;
        shadow_free     = s;
        r.read_data     = shadow_data[si];
      end
    end
    return r;
  endfunction

  // Pause length for one transaction; idle_pct 0 gives back-to-back traffic.
  function automatic int draw_pause(int idle_pct);
    if (int'($urandom_range(0, 99)) < idle_pct) return int'($urandom_range(0, MAX_GAP));
    return 0;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 30;
      default: return 100;
    endcase
  endfunction

  function automatic sbmq_in_t make_cmd(logic cmd, int q, logic [DATA_W-1:0] d);
    sbmq_in_t c;
    c.command    = cmd;
    c.queue_id   = QID_W'(q);
    c.write_data = d;
    return c;
  endfunction

  // Command driver
  int send_pause;
  int send_idle_pct;
  int send_count;

  always @(posedge clk_i or negedge rst_ni) begin
    int g;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      in_i          <= '0;
      send_pause    <= 0;
      send_idle_pct <= 0;
      send_count    <= 0;
    end else begin
      g = send_pause;
      if (in_valid_i && in_ready_o) begin
        g = draw_pause(send_idle_pct);
        send_count <= send_count + 1;
        if (send_count % 64 == 63) send_idle_pct <= pick_idle_pct();
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the transaction until it is taken
      end else if (g > 0) begin
        in_valid_i <= 1'b0;
        send_pause <= g - 1;
      end else if (pending_cmds.size() > 0) begin
        in_i       <= pending_cmds.pop_front();
        in_valid_i <= 1'b1;
        send_pause <= 0;
      end else begin
        in_valid_i <= 1'b0;
        send_pause <= 0;
      end
    end
  end

  // Predict on accepted commands, check accepted results, pace out_ready_i.
  int recv_pause;
  int recv_idle_pct;
  int recv_count;

  always @(posedge clk_i or negedge rst_ni) begin
    sbmq_out_t want;
    int        nxt;
    if (!rst_ni) begin
      out_ready_i   <= 1'b0;
      recv_pause    <= 0;
      recv_idle_pct <= 0;
      recv_count    <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        want = apply_command(in_i);
        expected_results.push_back(want);
        accepted_cmds++;
        case (want.status)
          ST_FULL:  enq_full++;
          ST_EMPTY: deq_empty++;
          default:  if (in_i.command == CMD_ENQ) enq_done++; else deq_done++;
        endcase
      end
      nxt = (recv_pause > 0) ? recv_pause - 1 : 0;
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result read_data=%0d status=%0d",
                   $realtime, out_o.read_data, out_o.status);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_o.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $realtime, want.status, out_o.status);
            error_count++;
          end
          if (out_o.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch: expected %0d, actual %0d",
                     $realtime, want.read_data, out_o.read_data);
            error_count++;
          end
        end
        nxt = draw_pause(recv_idle_pct);
        recv_count <= recv_count + 1;
        if (recv_count % 64 == 63) recv_idle_pct <= pick_idle_pct();
      end
      recv_pause  <= nxt;
      out_ready_i <= (nxt == 0);
    end
  end

  initial begin
    int               bias;
    int               focus;
    int               burst;
    int               q;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] corner [8];
    rst_ni        = 1'b0;
    accepted_cmds = 0;
    error_count   = 0;
    enq_done      = 0;
    enq_full      = 0;
    deq_done      = 0;
    deq_empty     = 0;
    reset_shadow();

    corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
               32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001};

    // Directed: empty dequeue, fill the store, overflow, slot reuse, drain to empty.
    pending_cmds.push_back(make_cmd(CMD_DEQ, 0, $urandom));
    for (int i = 0; i < NSLOTS; i++) begin
      d = (i < 8) ? corner[i] : $urandom;
      pending_cmds.push_back(make_cmd(CMD_ENQ, i % NQUEUES, d));
    end
    pending_cmds.push_back(make_cmd(CMD_ENQ, 2, 32'h1234_5678));
    pending_cmds.push_back(make_cmd(CMD_DEQ, 0, '0));
    pending_cmds.push_back(make_cmd(CMD_ENQ, 3, 32'hDEAD_BEEF));
    for (int i = 0; i < 5; i++) pending_cmds.push_back(make_cmd(CMD_DEQ, 3, $urandom));

    // Random: bursts leaning toward filling, toward draining or neither, often on one queue.
    while (pending_cmds.size() < RAND_CMDS + 25) begin
      case ($urandom_range(0, 2))
        0:       bias = 15;
        1:       bias = 50;
        default: bias = 85;
      endcase
      focus = $urandom_range(0, NQUEUES - 1);
      burst = $urandom_range(10, 40);
      for (int i = 0; i < burst; i++) begin
        q = ($urandom_range(0, 1) == 0) ? focus : int'($urandom_range(0, NQUEUES - 1));
        pending_cmds.push_back(make_cmd((int'($urandom_range(0, 99)) < bias) ? CMD_ENQ
                                                                             : CMD_DEQ,
                                        q, $urandom));
      end
    end
    total_cmds = pending_cmds.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cmds < total_cmds || expected_results.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Ran %0d commands: %0d enqueues stored, %0d refused as full,",
             accepted_cmds, enq_done, enq_full);
    $display("%0d dequeues returned data, %0d found the queue empty.", deq_done, deq_empty);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
